FILE: hdl/bse_pkg.sv
`default_nettype none
package bse_pkg;

   localparam int CHAR_W       = 8;
   localparam int IDX_W        = 7;
   localparam int CAP_W        = 16;
   localparam int PAIR_W       = 2 * CHAR_W;
   localparam int PAIR_ENTRIES = 128;
   localparam int SEL_IN_W     = 2;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 8;

   // first byte value that refers to a pair table entry
   localparam logic [CHAR_W-1:0] PAIR_BASE = 8'd128;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECODE = 1'b1
   } bse_op_type;

   // one decoded item: up to two characters, or the terminator
   typedef struct packed {
      logic [1:0]        count;
      logic [CHAR_W-1:0] char0;
      logic [CHAR_W-1:0] char1;
      logic              last;
   } bse_result_type;

endpackage
`default_nettype wire

FILE: hdl/bse_pair_mem.sv
`default_nettype none
module bse_pair_mem #(
   parameter  int TABLES = 4,
   localparam int SEL_W  = (TABLES > 1) ? $clog2(TABLES) : 1,
   localparam int ADDR_W = SEL_W + bse_pkg::IDX_W
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [bse_pkg::PAIR_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [bse_pkg::PAIR_W-1:0] rd_data
);
   import bse_pkg::*;

   localparam int DEPTH = TABLES * PAIR_ENTRIES;

   logic [PAIR_W-1:0] mem [DEPTH];
   logic [PAIR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read so a stalled item keeps its pair
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/bse_expand.sv
`default_nettype none
module bse_expand (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_load,
   input  wire logic [bse_pkg::CHAR_W-1:0] item_byte,
   input  wire logic [bse_pkg::CAP_W-1:0]  item_capacity,
   input  wire logic [bse_pkg::PAIR_W-1:0] pair_data,
   output logic                            item_ready,
   output logic                            res_valid,
   input  wire logic                       res_ready,
   output bse_pkg::bse_result_type         res
);
   import bse_pkg::*;

   logic              vld_ff, vld_in;
   logic [CHAR_W-1:0] byte_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic              open_ff, open_in;
   logic [CAP_W-1:0]  room_ff, room_in;
   logic              adv;
   logic [CAP_W-1:0]  room;
   logic [CHAR_W-1:0] p1;
   logic [CHAR_W-1:0] p2;

   assign adv        = vld_ff && res_ready;
   assign item_ready = !vld_ff || res_ready;
   assign res_valid  = vld_ff;
   assign p1         = pair_data[PAIR_W-1:CHAR_W];
   assign p2         = pair_data[CHAR_W-1:0];

   always_comb begin
      vld_in = item_load ? 1'b1 : (adv ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         open_ff <= 1'b0;
         room_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (adv) begin
            open_ff <= open_in;
            room_ff <= room_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         byte_ff <= item_byte;
         cap_ff  <= item_capacity;
      end
   end

   // a closed string takes its room from the capacity sent with its first byte
   always_comb begin
      room       = open_ff ? room_ff : cap_ff;
      open_in    = 1'b1;
      room_in    = room;
      res.count  = 2'd0;
      res.char0  = byte_ff;
      res.char1  = p2;
      res.last   = 1'b0;
      if (byte_ff == '0) begin
         open_in   = 1'b0;
         room_in   = '0;
         res.count = 2'd1;
         res.char0 = '0;
         res.last  = 1'b1;
      end else if (room <= CAP_W'(1)) begin
         // drop: only the terminator's room is left
         res.count = 2'd0;
      end else if (byte_ff >= PAIR_BASE && p1 != '0) begin
         res.char0 = p1;
         if (room > CAP_W'(2)) begin
            res.count = 2'd2;
            room_in   = room - CAP_W'(2);
         end else begin
            res.count = 2'd1;
            room_in   = room - CAP_W'(1);
         end
      end else begin
         res.count = 2'd1;
         room_in   = room - CAP_W'(1);
      end
   end

endmodule
`default_nettype wire

FILE: hdl/bse_out_buf.sv
`default_nettype none
module bse_out_buf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       res_valid,
   output logic                            res_ready,
   input  wire bse_pkg::bse_result_type    res,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [bse_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import bse_pkg::*;

   logic [1:0]        cnt_ff, cnt_in;
   logic [CHAR_W-1:0] char0_ff, char0_in;
   logic [CHAR_W-1:0] char1_ff, char1_in;
   logic              last_ff, last_in;
   logic              xfer;

   assign xfer       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = RSP_DATA_W'(char0_ff);
   assign rsp_tlast  = last_ff;
   assign res_ready  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);

   always_comb begin
      cnt_in   = cnt_ff;
      char0_in = char0_ff;
      char1_in = char1_ff;
      last_in  = last_ff;
      if (res_valid && res_ready) begin
         cnt_in   = res.count;
         char0_in = res.char0;
         char1_in = res.char1;
         last_in  = res.last;
      end else if (xfer) begin
         // advance to the pair's second character
         cnt_in   = cnt_ff - 2'd1;
         char0_in = char1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      char0_ff <= char0_in;
      char1_ff <= char1_in;
      last_ff  <= last_in;
   end

endmodule
`default_nettype wire

FILE: hdl/bigram_string_expander_top.sv
`default_nettype none
// Bigram string expander. Load transfers (tuser 0) write a two-character pair
// into the pair table chosen by csr_wdata; decode transfers (tuser 1) carry one
// compressed byte, which comes out as a copy, as a table pair (or its first
// character when room is short), or as nothing once the string's capacity is
// used up; a zero byte closes the string with a zero character marked tlast.
// A new item is taken every cycle while each gives at most one character and
// rsp_tready is high; a pair leaves the result channel one character per cycle
// while rsp_tready is high, and holds back the items behind it until its second
// character is sent. The first result passes through the pair table read and
// input register on the accepting edge, then the result register. The pair
// table needs no clearing pass: entries must be loaded before decodes refer to them.
module bigram_string_expander_top #(
   parameter int TABLES = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [bse_pkg::SEL_IN_W-1:0]  csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // entry_index[6:0], first_char[14:7], second_char[22:15], in_byte[30:23],
   // capacity[46:31], zero fill[47]
   input  wire logic [bse_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // out_char[7:0]
   output logic [bse_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import bse_pkg::*;

   localparam int SEL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int ADDR_W = SEL_W + IDX_W;

   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic [SEL_IN_W:0] sel_red;
   logic              xfer;
   logic              load_xfer;
   logic              decode_xfer;
   logic [IDX_W-1:0]  entry_index;
   logic [CHAR_W-1:0] first_char;
   logic [CHAR_W-1:0] second_char;
   logic [CHAR_W-1:0] in_byte;
   logic [CAP_W-1:0]  capacity;
   logic [PAIR_W-1:0] pair_data;
   logic              res_valid;
   logic              res_ready;
   bse_result_type    res;

   assign entry_index = req_tdata[6:0];
   assign first_char  = req_tdata[14:7];
   assign second_char = req_tdata[22:15];
   assign in_byte     = req_tdata[30:23];
   assign capacity    = req_tdata[46:31];

   assign xfer        = req_tvalid && req_tready;
   assign load_xfer   = xfer && (bse_op_type'(req_tuser) == OP_LOAD);
   assign decode_xfer = xfer && (bse_op_type'(req_tuser) == OP_DECODE);

   // wrap the table select into range at write time
   always_comb begin
      sel_red = {1'b0, csr_wdata};
      for (int i = 0; i < 3; i++) begin
         if (int'(sel_red) >= TABLES) begin
            sel_red = sel_red - (SEL_IN_W + 1)'(TABLES);
         end
      end
      sel_in = SEL_W'(sel_red);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (csr_we) begin
         sel_ff <= sel_in;
      end
   end

   bse_pair_mem #(
      .TABLES (TABLES)
   ) u_pair_mem (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr ({sel_ff, entry_index}),
      .wr_data ({first_char, second_char}),
      .rd_en   (decode_xfer),
      .rd_addr ({sel_ff, in_byte[IDX_W-1:0]}),
      .rd_data (pair_data)
   );

   bse_expand u_expand (
      .clock         (clock),
      .reset         (reset),
      .item_load     (decode_xfer),
      .item_byte     (in_byte),
      .item_capacity (capacity),
      .pair_data     (pair_data),
      .item_ready    (req_tready),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   bse_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: hdl/bse_checker.sv
`default_nettype none
module bse_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [bse_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                            rsp_tlast
);
   import bse_pkg::*;

   // terminator is always a zero character
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == '0)
      else $error("terminator carries a nonzero character");

   // input backpressure only comes from a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // leaving reset: empty pipeline, ready for input
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind bigram_string_expander_top bse_checker u_bse_checker (.*);
`default_nettype wire
